// ===== rtl/gfit_pkg.sv =====
// Shared constants, codes and control types of the grid first-fit unit.
package gfit_pkg;

   // Grid geometry and field widths.
   localparam int MAX_COLS   = 16;
   localparam int MAX_ROWS   = 16;
   localparam int OWNER_BITS = 16;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int LANES      = MAX_COLS;
   localparam int LANE_AW    = $clog2(LANES);
   localparam int WORDS      = CELL_COUNT / LANES;
   localparam int WORD_AW    = $clog2(WORDS);
   localparam int COL_W      = 4;
   localparam int ROW_W      = 4;
   localparam int DIM_W      = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   // Request command codes.
   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_FIND  = 1'b1
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 4'd0,
      REG_GRID_HEIGHT = 4'd1
   } csr_reg_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_ROWS,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_cell;
      logic load_find;
      logic sweep_step;
      logic row_step;
      logic respond;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_done;
      logic row_last;
   } sts_type;

endpackage

// ===== rtl/grid_rectangle_first_fit_unit.sv =====
// Top level of the grid first-fit unit: controller plus datapath.
//
//   Channel   Ports                                    Handshake
//   request   start, busy, req_*                       taken when start=1 and busy=0
//   response  rsp_strobe, rsp_found, rsp_pos_*         one cycle per word, no backpressure
//   config    csr_valid, csr_ready, csr_index, csr_wdata  taken when valid=1 and ready=1
//
// A cell write completes at the edge that accepts it; the next word may follow at once.
// A find sweeps the owner memory one 16-cell word per cycle, then walks the grid one row
// per cycle (rows = effective grid_height, at least 1). The result word rises once the
// sweep, the row walk and the finish state are through; busy stays high until the result
// shows, so the next word is taken no earlier than the edge that takes the result.
// Reset is synchronous and clears the written-cell flags at once,
// so no clearing pass follows it. The receiver cannot stall the result.
module grid_rectangle_first_fit_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [gfit_pkg::COL_W-1:0]          req_cell_col,
   input  logic [gfit_pkg::ROW_W-1:0]          req_cell_row,
   input  logic [gfit_pkg::OWNER_BITS-1:0]     req_cell_owner,
   input  logic [gfit_pkg::DIM_W-1:0]          req_rect_width,
   input  logic [gfit_pkg::DIM_W-1:0]          req_rect_height,
   input  logic                                req_scan_reversed,
   input  logic [gfit_pkg::OWNER_BITS-1:0]     req_own_id,
   output logic                                rsp_strobe,
   output logic                                rsp_found,
   output logic [gfit_pkg::COL_W-1:0]          rsp_pos_col,
   output logic [gfit_pkg::ROW_W-1:0]          rsp_pos_row,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gfit_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gfit_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gfit_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    csr_we;

   assign csr_we = csr_valid && csr_ready;

   // Sequencer.
   gfit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .csr_ready (csr_ready)
   );

   // Storage and search logic.
   gfit_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_cell_col      (req_cell_col),
      .req_cell_row      (req_cell_row),
      .req_cell_owner    (req_cell_owner),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .req_scan_reversed (req_scan_reversed),
      .req_own_id        (req_own_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_pos_col       (rsp_pos_col),
      .rsp_pos_row       (rsp_pos_row)
   );

endmodule

// ===== rtl/gfit_ctrl.sv =====
// Controller state machine that sequences writes and rectangle searches.
module gfit_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_cmd,
   input  gfit_pkg::sts_type sts,
   output gfit_pkg::ctl_type ctl,
   output logic             busy,
   output logic             csr_ready
);
   import gfit_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cmd_type'(req_cmd) == CMD_FIND) begin
                  ctl.load_find = 1'b1;
                  state_in      = ST_SWEEP;
               end else begin
                  ctl.write_cell = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            ctl.sweep_step = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            ctl.row_step = 1'b1;
            if (sts.row_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Writes and register updates are taken only between searches.
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

endmodule

// ===== rtl/gfit_datapath.sv =====
// Datapath: owner memory, usable-cell bitmap, row-by-row window check and result word.
module gfit_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  gfit_pkg::ctl_type                   ctl,
   output gfit_pkg::sts_type                   sts,
   input  logic                                csr_we,
   input  logic [gfit_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gfit_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [gfit_pkg::COL_W-1:0]          req_cell_col,
   input  logic [gfit_pkg::ROW_W-1:0]          req_cell_row,
   input  logic [gfit_pkg::OWNER_BITS-1:0]     req_cell_owner,
   input  logic [gfit_pkg::DIM_W-1:0]          req_rect_width,
   input  logic [gfit_pkg::DIM_W-1:0]          req_rect_height,
   input  logic                                req_scan_reversed,
   input  logic [gfit_pkg::OWNER_BITS-1:0]     req_own_id,
   output logic                                rsp_strobe,
   output logic                                rsp_found,
   output logic [gfit_pkg::COL_W-1:0]          rsp_pos_col,
   output logic [gfit_pkg::ROW_W-1:0]          rsp_pos_row
);
   import gfit_pkg::*;

   localparam int ROW_BASE_W = CELL_AW + 1;
   localparam int WIN_W      = 2 * MAX_COLS;

   // Configuration registers.
   logic [DIM_W-1:0] grid_width_ff;
   logic [DIM_W-1:0] grid_height_ff;
   logic [DIM_W-1:0] eff_w;
   logic [DIM_W-1:0] eff_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_W'(MAX_COLS);
         grid_height_ff <= DIM_W'(MAX_ROWS);
      end else if (csr_we) begin
         if (csr_index == REG_GRID_WIDTH) begin
            grid_width_ff <= csr_wdata;
         end
         if (csr_index == REG_GRID_HEIGHT) begin
            grid_height_ff <= csr_wdata;
         end
      end
   end

   // Oversized settings are clamped to the physical grid.
   assign eff_w = (grid_width_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width_ff;
   assign eff_h = (grid_height_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height_ff;

   // Cell write address: row times the current stride plus column.
   logic [CELL_AW:0]   wr_lin;
   logic [CELL_AW-1:0] wr_addr;
   logic               wr_ok;

   assign wr_lin  = (CELL_AW+1)'(req_cell_row) * (CELL_AW+1)'(eff_w)
                  + (CELL_AW+1)'(req_cell_col);
   assign wr_addr = wr_lin[CELL_AW-1:0];
   assign wr_ok   = ctl.write_cell
                  && (DIM_W'(req_cell_col) < eff_w)
                  && (DIM_W'(req_cell_row) < eff_h)
                  && (wr_lin < (CELL_AW+1)'(CELL_COUNT));

   // Owner memory, one word per group of lanes; valid bits mark written cells.
   logic [LANES*OWNER_BITS-1:0] mem [WORDS];
   logic [LANES*OWNER_BITS-1:0] rd_data_ff;
   logic [LANES-1:0]            rd_valid_ff;
   logic [CELL_COUNT-1:0]       valid_ff;
   logic [WORD_AW:0]            sweep_cnt_ff;
   logic [WORD_AW-1:0]          rd_word;

   assign rd_word = sweep_cnt_ff[WORD_AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr[CELL_AW-1 -: WORD_AW]][wr_addr[LANE_AW-1:0]*OWNER_BITS +: OWNER_BITS]
            <= req_cell_owner;
      end
      rd_data_ff  <= mem[rd_word];
      rd_valid_ff <= valid_ff[rd_word*LANES +: LANES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Search request, latched when a find word is accepted.
   logic [DIM_W-1:0]      w_ff;
   logic [DIM_W-1:0]      h_ff;
   logic [DIM_W-1:0]      gw_ff;
   logic [DIM_W-1:0]      gh_ff;
   logic                  rev_ff;
   logic [OWNER_BITS-1:0] own_ff;
   logic                  size_ok_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_find) begin
         w_ff       <= req_rect_width;
         h_ff       <= req_rect_height;
         gw_ff      <= eff_w;
         gh_ff      <= eff_h;
         rev_ff     <= req_scan_reversed;
         own_ff     <= req_own_id;
         size_ok_ff <= (req_rect_width != '0) && (req_rect_height != '0)
                    && (req_rect_width <= eff_w) && (req_rect_height <= eff_h);
      end
   end

   // Sweep counter and capture pipeline for the memory read.
   logic               cap_en_ff;
   logic [WORD_AW-1:0] cap_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         cap_en_ff    <= 1'b0;
      end else begin
         if (ctl.load_find) begin
            sweep_cnt_ff <= '0;
         end else if (ctl.sweep_step && !sweep_cnt_ff[WORD_AW]) begin
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         end
         cap_en_ff <= ctl.sweep_step && !sweep_cnt_ff[WORD_AW];
      end
   end

   always_ff @(posedge clock) begin
      cap_word_ff <= rd_word;
   end

   assign sts.sweep_done = (sweep_cnt_ff == (WORD_AW+1)'(WORDS));

   // A cell is usable when never written, free, or held by the requester.
   logic [LANES-1:0]      lane_ok;
   logic [CELL_COUNT-1:0] usable_ff;
   logic [CELL_COUNT+LANES-1:0] usable_ext;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_ok[i] = !rd_valid_ff[i]
                   || (rd_data_ff[i*OWNER_BITS +: OWNER_BITS] == '0)
                   || (rd_data_ff[i*OWNER_BITS +: OWNER_BITS] == own_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cap_en_ff) begin
         usable_ff[cap_word_ff*LANES +: LANES] <= lane_ok;
      end
   end

   assign usable_ext = {{LANES{1'b1}}, usable_ff};

   // Row walk: the logical row starts at row times stride in the flat bitmap.
   logic [ROW_W-1:0]      row_cnt_ff;
   logic [ROW_BASE_W-1:0] base_ff;
   logic [MAX_COLS-1:0]   row_bits;
   logic [DIM_W-1:0]      vrun_ff [MAX_COLS];
   logic [DIM_W-1:0]      vrun_in [MAX_COLS];
   logic [MAX_COLS-1:0]   vok;

   assign row_bits = usable_ext[base_ff +: MAX_COLS];

   // Vertical runs of usable cells ending at the current row.
   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         vrun_in[c] = row_bits[c] ? (vrun_ff[c] + 1'b1) : '0;
         vok[c]     = (vrun_in[c] >= h_ff);
      end
   end

   // Horizontal check of each left column against the run vector.
   logic [WIN_W-1:0]    vok_ext;
   logic [WIN_W-1:0]    win_mask;
   logic [MAX_COLS-1:0] fit;
   logic [DIM_W:0]      span_end;

   assign vok_ext  = {{(WIN_W-MAX_COLS){1'b0}}, vok};
   assign win_mask = WIN_W'(((WIN_W+1)'(1) << w_ff) - 1'b1);

   always_comb begin
      for (int x = 0; x < MAX_COLS; x++) begin
         span_end = (DIM_W+1)'(x) + (DIM_W+1)'(w_ff);
         fit[x]   = (span_end <= (DIM_W+1)'(gw_ff))
                 && ((vok_ext & (win_mask << x)) == (win_mask << x));
      end
   end

   // Lowest and highest fitting column of the row.
   logic [COL_W-1:0] lo_x;
   logic [COL_W-1:0] hi_x;
   logic             any_fit;
   logic [DIM_W-1:0] top_y;

   always_comb begin
      lo_x = '0;
      hi_x = '0;
      for (int x = MAX_COLS - 1; x >= 0; x--) begin
         if (fit[x]) begin
            lo_x = COL_W'(x);
         end
      end
      for (int x = 0; x < MAX_COLS; x++) begin
         if (fit[x]) begin
            hi_x = COL_W'(x);
         end
      end
   end

   assign any_fit = |fit;
   assign top_y   = DIM_W'(row_cnt_ff) + 1'b1 - h_ff;
   assign sts.row_last = ((DIM_W'(row_cnt_ff) + 1'b1) >= gh_ff);

   // First hit serves a forward scan, last hit a backward one.
   logic             first_v_ff;
   logic [COL_W-1:0] first_x_ff;
   logic [ROW_W-1:0] first_y_ff;
   logic             last_v_ff;
   logic [COL_W-1:0] last_x_ff;
   logic [ROW_W-1:0] last_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         base_ff    <= '0;
         first_v_ff <= 1'b0;
         last_v_ff  <= 1'b0;
         for (int c = 0; c < MAX_COLS; c++) begin
            vrun_ff[c] <= '0;
         end
      end else if (ctl.load_find) begin
         row_cnt_ff <= '0;
         base_ff    <= '0;
         first_v_ff <= 1'b0;
         last_v_ff  <= 1'b0;
         for (int c = 0; c < MAX_COLS; c++) begin
            vrun_ff[c] <= '0;
         end
      end else if (ctl.row_step) begin
         row_cnt_ff <= row_cnt_ff + 1'b1;
         base_ff    <= base_ff + ROW_BASE_W'(gw_ff);
         for (int c = 0; c < MAX_COLS; c++) begin
            vrun_ff[c] <= vrun_in[c];
         end
         if (any_fit) begin
            last_v_ff <= 1'b1;
            if (!first_v_ff) begin
               first_v_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.row_step && any_fit) begin
         last_x_ff <= hi_x;
         last_y_ff <= top_y[ROW_W-1:0];
         if (!first_v_ff) begin
            first_x_ff <= lo_x;
            first_y_ff <= top_y[ROW_W-1:0];
         end
      end
   end

   // Result word.
   logic             sel_found;
   logic [COL_W-1:0] sel_x;
   logic [ROW_W-1:0] sel_y;
   logic             strobe_ff;
   logic             found_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   assign sel_found = size_ok_ff && (rev_ff ? last_v_ff : first_v_ff);
   assign sel_x     = rev_ff ? last_x_ff : first_x_ff;
   assign sel_y     = rev_ff ? last_y_ff : first_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         found_ff <= sel_found;
         col_ff   <= sel_found ? sel_x : '0;
         row_ff   <= sel_found ? sel_y : '0;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_found   = found_ff;
   assign rsp_pos_col = col_ff;
   assign rsp_pos_row = row_ff;

endmodule

// ===== rtl/gfit_checker.sv =====
// Port-level checker for the grid first-fit unit and its bind.
module gfit_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_cmd,
   input logic                            rsp_strobe,
   input logic                            rsp_found,
   input logic [gfit_pkg::COL_W-1:0]      rsp_pos_col,
   input logic [gfit_pkg::ROW_W-1:0]      rsp_pos_row
);
   import gfit_pkg::*;

   // An accepted find holds the unit busy in the next cycle.
   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_FIND)) |=> busy)
      else $error("find accepted without entering busy");

   // A cell write leaves the unit free for the next word.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_WRITE)) |=> !busy)
      else $error("cell write left the unit busy");

   // A result word only ends a search that held the unit busy.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result word without a preceding search");

   // A miss reports the origin.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> ((rsp_pos_col == '0) && (rsp_pos_row == '0)))
      else $error("miss with nonzero position");

endmodule

bind grid_rectangle_first_fit_unit gfit_checker u_gfit_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_cmd     (req_cmd),
   .rsp_strobe  (rsp_strobe),
   .rsp_found   (rsp_found),
   .rsp_pos_col (rsp_pos_col),
   .rsp_pos_row (rsp_pos_row)
);
